FILE: rtl/fdn_pkg.sv
// fdn_pkg: shared constants, types and Q15 helpers for the four-line reverb
// no dependencies
package fdn_pkg;

    localparam int LEN_ONE_DEF   = 8;
    localparam int LEN_TWO_DEF   = 10;
    localparam int LEN_THREE_DEF = 12;
    localparam int LEN_FOUR_DEF  = 14;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
    localparam int PROD_W     = 2 * SAMPLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

    localparam logic signed [SAMPLE_W-1:0] SCALE_RESET = 16'sd23169;
    localparam logic signed [SAMPLE_W-1:0] GAIN_RESET  = 16'sd16383;

    localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

    // one-hot sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_WB   = 3'b100
    } t_state;

    // saturating add of two q15 values
    function automatic logic signed [SAMPLE_W-1:0] sat_add(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W:0] s;
        s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        if (s[SAMPLE_W] != s[SAMPLE_W-1])
            sat_add = s[SAMPLE_W] ? Q15_MIN : Q15_MAX;
        else
            sat_add = s[SAMPLE_W-1:0];
    endfunction

    // q15 product with the coefficient 32767
    function automatic logic signed [SAMPLE_W-1:0] mul_max(
        input logic signed [SAMPLE_W-1:0] t
    );
        if (t > 0)
            mul_max = t - 16'sd1;
        else if (t == Q15_MIN)
            mul_max = -16'sd32767;
        else
            mul_max = t;
    endfunction

    // q15 product with the coefficient -32768
    function automatic logic signed [SAMPLE_W-1:0] mul_min(
        input logic signed [SAMPLE_W-1:0] t
    );
        if (t == Q15_MIN)
            mul_min = Q15_MAX;
        else
            mul_min = -t;
    endfunction

endpackage

FILE: rtl/fdn_reverb_q15.sv
// fdn_reverb_q15: four-line feedback delay network reverb on q15 samples
// depends on fdn_pkg; delay lines are shift registers, gains use a radix-16 serial multiplier
//
// One sample is taken per transaction. The output sample is formed in the cycle the
// input is accepted and lands in the output register; the feedback path then runs
// eight q15 multiplies (scale then gain for each of the four lines) on one shared
// 16x4-bit digit-serial multiplier, followed by a write-back state. No new sample is
// accepted until the sequencer is back in idle. Configuration writes are taken in any
// cycle and take effect from the next multiply that loads the coefficient.
module fdn_reverb_q15 #(
    parameter int LEN_ONE   = fdn_pkg::LEN_ONE_DEF,
    parameter int LEN_TWO   = fdn_pkg::LEN_TWO_DEF,
    parameter int LEN_THREE = fdn_pkg::LEN_THREE_DEF,
    parameter int LEN_FOUR  = fdn_pkg::LEN_FOUR_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [fdn_pkg::SAMPLE_W-1:0]   i_in_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [fdn_pkg::SAMPLE_W-1:0]   o_out_sample,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fdn_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic signed [fdn_pkg::SAMPLE_W-1:0]   i_cfg_data
);

    localparam int W  = fdn_pkg::SAMPLE_W;
    localparam int DW = fdn_pkg::DIGIT_W;
    localparam int PW = fdn_pkg::PROD_W;

    fdn_pkg::t_state r_state, n_state;

    logic signed [W-1:0] r_line1 [LEN_ONE];
    logic signed [W-1:0] r_line2 [LEN_TWO];
    logic signed [W-1:0] r_line3 [LEN_THREE];
    logic signed [W-1:0] r_line4 [LEN_FOUR];

    logic signed [W-1:0] r_scale, r_gain;
    logic signed [W-1:0] r_acc [4];
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_out;
    logic                r_out_valid;
    logic [1:0]          r_k;
    logic                r_pass;
    logic [1:0]          r_dig;
    logic [W-1:0]        r_b;
    logic signed [PW-1:0] r_prod;

    logic signed [W-1:0] t0, t1, t2, t3;
    logic signed [W-1:0] mix [4];
    logic signed [W-1:0] y;
    logic                in_acc;
    logic                mul_last;
    logic [DW:0]         digit;
    logic signed [W+DW:0] part;
    logic signed [PW-1:0] part_ext;
    logic signed [PW-1:0] n_prod;
    logic signed [W-1:0]  q_res;

    assign t0 = r_line1[LEN_ONE-1];
    assign t1 = r_line2[LEN_TWO-1];
    assign t2 = r_line3[LEN_THREE-1];
    assign t3 = r_line4[LEN_FOUR-1];

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == fdn_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out;

    // output sum and matrix rows from the current taps
    always_comb begin
        y = fdn_pkg::sat_add(i_in_sample,
                fdn_pkg::sat_add(fdn_pkg::sat_add(t2, fdn_pkg::sat_add(t0, t1)), t3));
        mix[0] = fdn_pkg::sat_add(fdn_pkg::mul_max(t1), fdn_pkg::mul_max(t2));
        mix[1] = fdn_pkg::sat_add(fdn_pkg::mul_min(t0), fdn_pkg::mul_min(t3));
        mix[2] = fdn_pkg::sat_add(fdn_pkg::mul_max(t0), fdn_pkg::mul_min(t3));
        mix[3] = fdn_pkg::sat_add(fdn_pkg::mul_max(t1), fdn_pkg::mul_min(t2));
    end

    // digit-serial multiply step, top digit signed
    always_comb begin
        mul_last = (r_dig == 2'(fdn_pkg::NUM_DIGITS - 1));
        digit    = mul_last ? {r_b[DW-1], r_b[DW-1:0]} : {1'b0, r_b[DW-1:0]};
        part     = r_acc[r_k] * $signed(digit);
        part_ext = PW'(part);
        n_prod   = r_prod + (part_ext <<< {r_dig, 2'b00});
        if (n_prod >= (PW'(1) <<< (2 * W - 2)))
            q_res = fdn_pkg::Q15_MAX;
        else
            q_res = n_prod[2*W-2:W-1];
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fdn_pkg::S_IDLE: if (in_acc) n_state = fdn_pkg::S_MUL;
            fdn_pkg::S_MUL:  if (mul_last && r_pass && r_k == 2'd3) n_state = fdn_pkg::S_WB;
            fdn_pkg::S_WB:   n_state = fdn_pkg::S_IDLE;
            default:         n_state = fdn_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fdn_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_pass      <= 1'b0;
            r_dig       <= '0;
            r_scale     <= fdn_pkg::SCALE_RESET;
            r_gain      <= fdn_pkg::GAIN_RESET;
        end else begin
            r_state <= n_state;
            if (in_acc)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == fdn_pkg::REG_SCALE) r_scale <= i_cfg_data;
                if (i_cfg_index == fdn_pkg::REG_GAIN)  r_gain  <= i_cfg_data;
            end
            if (in_acc) begin
                r_k    <= '0;
                r_pass <= 1'b0;
                r_dig  <= '0;
            end else if (r_state == fdn_pkg::S_MUL) begin
                r_dig <= r_dig + 2'd1;
                if (mul_last) begin
                    r_pass <= !r_pass;
                    if (r_pass) r_k <= r_k + 2'd1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out  <= y;
            r_x    <= i_in_sample;
            r_acc  <= mix;
            r_b    <= r_scale;
            r_prod <= '0;
        end else if (r_state == fdn_pkg::S_MUL) begin
            if (mul_last) begin
                r_acc[r_k] <= q_res;
                r_b        <= r_pass ? r_scale : r_gain;
                r_prod     <= '0;
            end else begin
                r_b    <= r_b >> DW;
                r_prod <= n_prod;
            end
        end
    end

    // delay lines: write back the feedback sample and shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEN_ONE; i++)   r_line1[i] <= '0;
            for (int i = 0; i < LEN_TWO; i++)   r_line2[i] <= '0;
            for (int i = 0; i < LEN_THREE; i++) r_line3[i] <= '0;
            for (int i = 0; i < LEN_FOUR; i++)  r_line4[i] <= '0;
        end else if (r_state == fdn_pkg::S_WB) begin
            for (int i = 1; i < LEN_ONE; i++)   r_line1[i] <= r_line1[i-1];
            for (int i = 1; i < LEN_TWO; i++)   r_line2[i] <= r_line2[i-1];
            for (int i = 1; i < LEN_THREE; i++) r_line3[i] <= r_line3[i-1];
            for (int i = 1; i < LEN_FOUR; i++)  r_line4[i] <= r_line4[i-1];
            r_line1[0] <= fdn_pkg::sat_add(r_acc[0], r_x);
            r_line2[0] <= fdn_pkg::sat_add(r_acc[1], r_x);
            r_line3[0] <= fdn_pkg::sat_add(r_acc[2], r_x);
            r_line4[0] <= fdn_pkg::sat_add(r_acc[3], r_x);
        end
    end

    // checks
    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == fdn_pkg::S_MUL))
        else $error("accepted sample did not start the multiply sequence");
    a_wb_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fdn_pkg::S_WB) |=> (r_state == fdn_pkg::S_IDLE))
        else $error("write-back not followed by idle");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == fdn_pkg::S_IDLE))
        else $error("input ready while busy");
    a_wb_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fdn_pkg::S_WB) |-> ($past(r_k) == 2'd3 && $past(mul_last)))
        else $error("write-back before all lines were scaled");

endmodule
